[hdl/first_fit_extent_allocator_top_macros.svh]
// assertion macros for the extent allocator
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define FFEA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequence is checked in the cycle after the antecedent
`define FFEA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hdl/ffea_pkg.sv]
// shared constants and types of the extent allocator
package ffea_pkg;
	localparam int MaxExtents = 64;
	localparam int OffsetBits = 32;
	localparam int IdxBits = $clog2(MaxExtents);
	localparam int CntBits = $clog2(MaxExtents + 1);
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVERLAP = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;
	typedef logic [OffsetBits-1:0] off_t;
	typedef logic [IdxBits-1:0] idx_t;
	typedef logic [CntBits-1:0] cnt_t;
	typedef struct packed {
		logic we;
		idx_t waddr;
		off_t wstart;
		off_t wend;
		idx_t raddr;
	} mem_req_t;
	typedef struct packed {
		off_t rstart;
		off_t rend;
	} mem_rsp_t;
endpackage

[hdl/ffea_ext_mem.sv]
// extent table: start and end offsets, one write and one registered read port
module ffea_ext_mem (
	input logic clk,
	input ffea_pkg::mem_req_t req,
	output ffea_pkg::mem_rsp_t rsp
);
	ffea_pkg::off_t start_mem [ffea_pkg::MaxExtents];
	ffea_pkg::off_t end_mem [ffea_pkg::MaxExtents];

	always_ff @(posedge clk) begin
		if (req.we) begin
			start_mem[req.waddr] <= req.wstart;
			end_mem[req.waddr] <= req.wend;
		end
		rsp.rstart <= start_mem[req.raddr];
		rsp.rend <= end_mem[req.raddr];
	end
endmodule

[hdl/ffea_ctrl.sv]
// sequencer: first-fit search, sorted insert and delete over the extent table
module ffea_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic opcode,
	input ffea_pkg::off_t position,
	input ffea_pkg::off_t length,
	output logic out_valid,
	input logic out_stall,
	output ffea_pkg::off_t offset,
	output logic [1:0] status,
	output ffea_pkg::mem_req_t req,
	input ffea_pkg::mem_rsp_t rsp
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_CHK = 3'd2;
	localparam logic [2:0] S_DEL_RD = 3'd3;
	localparam logic [2:0] S_DEL_WR = 3'd4;
	localparam logic [2:0] S_INS_RD = 3'd5;
	localparam logic [2:0] S_INS_WR = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;
	logic op_q;
	ffea_pkg::off_t pos_q, len_q, eos_q;
	ffea_pkg::cnt_t cnt_q, idx_q, ins_q;
	// last entry passed during a free scan, the left neighbour
	ffea_pkg::off_t prev_start_q, prev_end_q;
	logic have_prev_q;
	logic res_valid_q;
	ffea_pkg::off_t res_off_q;
	logic [1:0] res_st_q;

	ffea_pkg::off_t fr_end;
	logic [ffea_pkg::OffsetBits:0] fr_sum;
	ffea_pkg::off_t ext_size;
	ffea_pkg::cnt_t idx_inc, idx_dec;
	logic at_end, fr_empty, fr_place, nxt_here, fr_ovl, fr_jn, fr_jp, al_fit;

	assign fr_sum = {1'b0, pos_q} + {1'b0, len_q};
	assign fr_end = fr_sum[ffea_pkg::OffsetBits] ? '1 : fr_sum[ffea_pkg::OffsetBits-1:0];
	assign ext_size = rsp.rend - rsp.rstart;
	assign idx_inc = idx_q + ffea_pkg::cnt_t'(1);
	assign idx_dec = idx_q - ffea_pkg::cnt_t'(1);
	assign at_end = (idx_q == cnt_q);
	assign fr_empty = (fr_end == pos_q);
	// free: insertion point reached, with or without a following entry
	assign fr_place = (op_q == ffea_pkg::OP_FREE) &&
		((state_q == S_RD && at_end && !fr_empty) ||
		(state_q == S_CHK && rsp.rstart >= pos_q));
	assign nxt_here = (state_q == S_CHK);
	assign fr_ovl = nxt_here && (rsp.rstart < fr_end);
	assign fr_jn = nxt_here && (rsp.rstart == fr_end);
	assign fr_jp = have_prev_q && (prev_end_q == pos_q);
	assign al_fit = (op_q == ffea_pkg::OP_ALLOC) && (state_q == S_CHK) && (ext_size >= len_q);

	assign in_stall = (state_q != S_IDLE) || (res_valid_q && out_stall);
	assign out_valid = res_valid_q;
	assign offset = res_off_q;
	assign status = res_st_q;

	always_comb begin
		req = '0;
		req.raddr = idx_q[ffea_pkg::IdxBits-1:0];
		case (state_q)
			S_RD, S_CHK: begin
				if (al_fit && len_q != '0 && ext_size != len_q) begin
					// shrink the extent from the front
					req.we = 1'b1;
					req.waddr = idx_q[ffea_pkg::IdxBits-1:0];
					req.wstart = rsp.rstart + len_q;
					req.wend = rsp.rend;
				end else if (fr_place && !fr_ovl && fr_jp) begin
					req.we = 1'b1;
					req.waddr = idx_dec[ffea_pkg::IdxBits-1:0];
					req.wstart = prev_start_q;
					req.wend = fr_jn ? rsp.rend : fr_end;
				end else if (fr_place && !fr_ovl && fr_jn) begin
					req.we = 1'b1;
					req.waddr = idx_q[ffea_pkg::IdxBits-1:0];
					req.wstart = pos_q;
					req.wend = rsp.rend;
				end
			end
			S_DEL_RD: begin
				req.raddr = idx_inc[ffea_pkg::IdxBits-1:0];
			end
			S_DEL_WR: begin
				// pull entry idx_q+1 down into idx_q
				req.we = 1'b1;
				req.waddr = idx_q[ffea_pkg::IdxBits-1:0];
				req.wstart = rsp.rstart;
				req.wend = rsp.rend;
			end
			S_INS_RD: begin
				req.raddr = idx_dec[ffea_pkg::IdxBits-1:0];
				if (idx_q == ins_q) begin
					req.we = 1'b1;
					req.waddr = idx_q[ffea_pkg::IdxBits-1:0];
					req.wstart = pos_q;
					req.wend = fr_end;
				end
			end
			S_INS_WR: begin
				// push entry idx_q-1 up into idx_q
				req.we = 1'b1;
				req.waddr = idx_q[ffea_pkg::IdxBits-1:0];
				req.wstart = rsp.rstart;
				req.wend = rsp.rend;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= ffea_pkg::OP_ALLOC;
			pos_q <= '0;
			len_q <= '0;
			eos_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			ins_q <= '0;
			prev_start_q <= '0;
			prev_end_q <= '0;
			have_prev_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_off_q <= '0;
			res_st_q <= ffea_pkg::ST_OK;
		end else begin
			if (state_q == S_DONE) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						op_q <= opcode;
						pos_q <= position;
						len_q <= length;
						idx_q <= '0;
						have_prev_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD, S_CHK: begin
					if (fr_place) begin
						res_off_q <= '0;
						res_st_q <= ffea_pkg::ST_OK;
						if (fr_ovl) begin
							res_st_q <= ffea_pkg::ST_OVERLAP;
							state_q <= S_DONE;
						end else if (fr_jn && fr_jp) begin
							// left neighbour already widened, drop entry idx_q
							state_q <= S_DEL_RD;
						end else if (fr_jn || fr_jp) begin
							state_q <= S_DONE;
						end else if (cnt_q == ffea_pkg::cnt_t'(ffea_pkg::MaxExtents)) begin
							res_st_q <= ffea_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							ins_q <= idx_q;
							idx_q <= cnt_q;
							state_q <= S_INS_RD;
						end
					end else if (state_q == S_RD) begin
						if (op_q == ffea_pkg::OP_ALLOC && at_end) begin
							if (len_q > ~eos_q) begin
								res_off_q <= '0;
								res_st_q <= ffea_pkg::ST_EXHAUSTED;
							end else begin
								res_off_q <= eos_q;
								res_st_q <= ffea_pkg::ST_OK;
								eos_q <= eos_q + len_q;
							end
							state_q <= S_DONE;
						end else if (op_q == ffea_pkg::OP_FREE && fr_empty) begin
							res_off_q <= '0;
							res_st_q <= ffea_pkg::ST_OK;
							state_q <= S_DONE;
						end else begin
							state_q <= S_CHK;
						end
					end else if (op_q == ffea_pkg::OP_ALLOC) begin
						if (al_fit) begin
							res_off_q <= rsp.rstart;
							res_st_q <= ffea_pkg::ST_OK;
							if (len_q != '0 && ext_size == len_q) begin
								state_q <= S_DEL_RD;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							idx_q <= idx_inc;
							state_q <= S_RD;
						end
					end else begin
						prev_start_q <= rsp.rstart;
						prev_end_q <= rsp.rend;
						have_prev_q <= 1'b1;
						idx_q <= idx_inc;
						state_q <= S_RD;
					end
				end
				S_DEL_RD: begin
					if (idx_inc == cnt_q) begin
						cnt_q <= cnt_q - ffea_pkg::cnt_t'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_DEL_WR;
					end
				end
				S_DEL_WR: begin
					idx_q <= idx_inc;
					state_q <= S_DEL_RD;
				end
				S_INS_RD: begin
					if (idx_q == ins_q) begin
						cnt_q <= cnt_q + ffea_pkg::cnt_t'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					idx_q <= idx_dec;
					state_q <= S_INS_RD;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "first_fit_extent_allocator_top_macros.svh"
	`FFEA_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= ffea_pkg::cnt_t'(ffea_pkg::MaxExtents))
	`FFEA_ASSERT_IMPL(a_busy_stall, state_q != S_IDLE, in_stall)
	`FFEA_ASSERT_NEXT(a_done_out, state_q == S_DONE, out_valid)
	`FFEA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(offset) && $stable(status))
endmodule

[hdl/first_fit_extent_allocator_top.sv]
// a request takes longer for each table entry that it scans or moves
// one item at a time: the next is accepted when the result leaves
// the rate is set by the single read port of the extent table
// reset clears the extent count, end mark and handshake state; the table is not cleared
// top level of the first-fit extent allocator
module first_fit_extent_allocator_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic opcode,
	input logic [31:0] position,
	input logic [31:0] length,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] offset,
	output logic [1:0] status
);
	ffea_pkg::mem_req_t req;
	ffea_pkg::mem_rsp_t rsp;

	ffea_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .position(position), .length(length),
		.out_valid(out_valid), .out_stall(out_stall),
		.offset(offset), .status(status),
		.req(req), .rsp(rsp)
	);

	ffea_ext_mem u_mem (.clk(clk), .req(req), .rsp(rsp));
endmodule

[tb/first_fit_extent_allocator_top_tb.sv]
// self-checking testbench of the first-fit extent allocator
`timescale 1ns / 1ps

class extent_scoreboard;
	logic [31:0] free_lo[$];
	logic [31:0] free_hi[$];
	logic [31:0] space_mark;
	logic [31:0] want_offset[$];
	logic [1:0] want_status[$];
	int errors;

	function void clear();
		free_lo.delete();
		free_hi.delete();
		space_mark = '0;
		want_offset.delete();
		want_status.delete();
		errors = 0;
	endfunction

	// notes an accepted item and works out its result
	function void note_request(logic op, logic [31:0] pos, logic [31:0] len);
		logic [31:0] res_off;
		logic [1:0] res_st;
		logic [32:0] ext_end;
		logic [31:0] e;
		int i;
		bit found;
		bit join_next;
		bit join_prev;
		res_off = '0;
		res_st = ffea_pkg::ST_OK;
		found = 0;
		if (op == ffea_pkg::OP_ALLOC) begin
			for (i = 0; i < free_lo.size(); i++) begin
				if (free_hi[i] - free_lo[i] >= len) begin
					res_off = free_lo[i];
					free_lo[i] = free_lo[i] + len;
					if (free_lo[i] == free_hi[i]) begin
						free_lo.delete(i);
						free_hi.delete(i);
					end
					found = 1;
					break;
				end
			end
			if (!found) begin
				if (len > 32'hFFFF_FFFF - space_mark) begin
					res_st = ffea_pkg::ST_EXHAUSTED;
				end else begin
					res_off = space_mark;
					space_mark = space_mark + len;
				end
			end
		end else begin
			ext_end = {1'b0, pos} + {1'b0, len};
			e = ext_end[32] ? 32'hFFFF_FFFF : ext_end[31:0];
			if (e != pos) begin
				i = 0;
				while (i < free_lo.size() && free_lo[i] < pos) i++;
				if (i < free_lo.size() && free_lo[i] < e) begin
					res_st = ffea_pkg::ST_OVERLAP;
				end else begin
					join_next = (i < free_lo.size()) && (free_lo[i] == e);
					join_prev = (i > 0) && (free_hi[i-1] == pos);
					if (join_next && join_prev) begin
						free_hi[i-1] = free_hi[i];
						free_lo.delete(i);
						free_hi.delete(i);
					end else if (join_prev) begin
						free_hi[i-1] = e;
					end else if (join_next) begin
						free_lo[i] = pos;
					end else if (free_lo.size() >= ffea_pkg::MaxExtents) begin
						res_st = ffea_pkg::ST_FULL;
					end else begin
						free_lo.insert(i, pos);
						free_hi.insert(i, e);
					end
				end
			end
		end
		want_offset.push_back(res_off);
		want_status.push_back(res_st);
	endfunction

	function void check_result(logic [31:0] off, logic [1:0] st);
		logic [31:0] eo;
		logic [1:0] es;
		if (want_offset.size() == 0) begin
			$error("result with nothing expected: offset %h status %0d", off, st);
			errors++;
			return;
		end
		eo = want_offset.pop_front();
		es = want_status.pop_front();
		if (off !== eo) begin
			$error("offset: expected %h actual %h", eo, off);
			errors++;
		end
		if (st !== es) begin
			$error("status: expected %0d actual %0d", es, st);
			errors++;
		end
	endfunction
endclass

module first_fit_extent_allocator_top_tb;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [31:0] position;
	logic [31:0] length;
	logic out_valid;
	logic out_stall;
	logic [31:0] offset;
	logic [1:0] status;

	extent_scoreboard extent_sb;
	bit calm;
	logic [31:0] alloc_lo[$];
	logic [31:0] alloc_len[$];

	first_fit_extent_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.position(position),
		.length(length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.offset(offset),
		.status(status)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#50_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: random stall bursts, checks every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				extent_sb.check_result(offset, status);
			end
		end
	end

	initial begin : stall_gen
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 9);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// valid stays high after an accept until the next item or an idle burst replaces it
	task automatic send_request(logic op, logic [31:0] pos, logic [31:0] len);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		position <= pos;
		length <= len;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		extent_sb.note_request(op, pos, len);
		if (op == ffea_pkg::OP_ALLOC && len != 0 && extent_sb.want_status[$] == ffea_pkg::ST_OK)
		begin
			alloc_lo.push_back(extent_sb.want_offset[$]);
			alloc_len.push_back(len);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (extent_sb.want_offset.size() != 0) @(posedge clk);
	endtask

	// give back a piece of a previously allocated block
	task automatic free_some();
		int k;
		logic [31:0] cut;
		k = $urandom_range(0, alloc_lo.size() - 1);
		cut = $urandom_range(1, alloc_len[k]);
		send_request(ffea_pkg::OP_FREE, alloc_lo[k], cut);
		if (cut == alloc_len[k]) begin
			alloc_lo.delete(k);
			alloc_len.delete(k);
		end else begin
			alloc_lo[k] = alloc_lo[k] + cut;
			alloc_len[k] = alloc_len[k] - cut;
		end
	endtask

	initial begin
		int i;
		int r;
		extent_sb = new();
		extent_sb.clear();
		calm = 0;
		in_valid = 1'b0;
		opcode = ffea_pkg::OP_ALLOC;
		position = '0;
		length = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, zero length, gaps, merges, overlap, clamp, exhaustion
		send_request(ffea_pkg::OP_ALLOC, 32'h0, 32'h0);
		send_request(ffea_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd100);
		send_request(ffea_pkg::OP_ALLOC, 32'h0, 32'd50);
		send_request(ffea_pkg::OP_FREE, 32'd10, 32'd10);
		send_request(ffea_pkg::OP_FREE, 32'd30, 32'd10);
		send_request(ffea_pkg::OP_FREE, 32'd20, 32'd10);
		send_request(ffea_pkg::OP_FREE, 32'd5, 32'd10);
		send_request(ffea_pkg::OP_FREE, 32'd60, 32'd0);
		send_request(ffea_pkg::OP_FREE, 32'd0, 32'd5);
		send_request(ffea_pkg::OP_ALLOC, 32'h0, 32'h0);
		send_request(ffea_pkg::OP_ALLOC, 32'h0, 32'd45);
		send_request(ffea_pkg::OP_ALLOC, 32'h0, 32'd5);
		send_request(ffea_pkg::OP_FREE, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_request(ffea_pkg::OP_FREE, 32'hFFFF_FFFF, 32'd1);
		send_request(ffea_pkg::OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
		send_request(ffea_pkg::OP_ALLOC, 32'h0, 32'h0FFF_FFFF);
		send_request(ffea_pkg::OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
		send_request(ffea_pkg::OP_ALLOC, 32'h0, 32'hFFFF_FF00);
		// fill the table with isolated extents until full
		for (i = 0; i < 66; i++) begin
			send_request(ffea_pkg::OP_FREE, 32'h8000_0000 + i * 4, 32'd2);
		end
		// coalescing into a full table still works
		send_request(ffea_pkg::OP_FREE, 32'h8000_0002, 32'd2);
		wait_drained();

		// random: allocations, frees of allocated pieces and some random frees as noise
		for (i = 0; i < 370; i++) begin
			if (i == 180) begin
				wait_drained();
			end
			if (i >= 300) calm = 1;
			r = $urandom_range(0, 9);
			if (r < 4) begin
				send_request(ffea_pkg::OP_ALLOC, $urandom(),
					($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 64));
			end else if (r < 8 && alloc_lo.size() != 0) begin
				free_some();
			end else begin
				send_request(ffea_pkg::OP_FREE, $urandom(),
					($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 64));
			end
		end
		calm = 1;
		wait_drained();
		repeat (200) @(posedge clk);
		if (extent_sb.errors == 0 && extent_sb.want_offset.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+hdl
hdl/ffea_pkg.sv
hdl/ffea_ext_mem.sv
hdl/ffea_ctrl.sv
hdl/first_fit_extent_allocator_top.sv
tb/first_fit_extent_allocator_top_tb.sv
